/* rtl/spq_pkg.sv */
// spq_pkg: shared types and constants for the strict-priority packet queues.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int SPQ_NUM_PRIORITIES = 8;
    localparam int SPQ_QUEUE_DEPTH    = 16;
    localparam int SPQ_MAX_SEND       = 16;
    localparam int SPQ_RESULT_CAP     = 16;

    localparam int SPQ_HANDLE_W = 16;
    localparam int SPQ_PRIO_W   = 3;
    localparam int SPQ_LIMIT_W  = 5;

    localparam logic SPQ_CMD_RECEIVE = 1'b0;
    localparam logic SPQ_CMD_SEND    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_SEND_RD,
        ST_SEND_WAIT
    } spq_state_t;

endpackage

/* rtl/strict_priority_packet_queues.sv */
// strict_priority_packet_queues: per-class handle FIFOs in one RAM, strict-priority send.
// Depends on spq_pkg and spq_ram.
//
// Input channel (s_*): one transfer per command. A receive appends s_packet_handle
// to the FIFO of class s_priority_req (ignored if the class does not exist). A full
// FIFO is first compacted by dropping every second entry, then the handle is added.
// A send emits up to s_send_limit handles on the result channel (m_*), highest
// non-empty class first, oldest first within a class; m_last marks the final one.
// A send that finds every FIFO empty gives one result with m_none_sent and m_last.
//
// Timing: a receive into a full FIFO walks the surviving half through the RAM, one
// entry per cycle (one read and one write port). For each result a send does a RAM
// read of the head, a load of the output register, then the transfer of that result
// before the next head is read; a stalled m_ready holds the output register and the
// send waits for it. s_ready is high only when no command is in progress, but a new
// command is taken while the last result still waits. A zero s_send_limit counts as
// 1, and a send never gives more than 16 results.
// Reset clears fill counts, head pointers and the output valid; the RAM needs no
// clearing since only entries below a class's fill are ever read.
module strict_priority_packet_queues
    import spq_pkg::*;
#(
    parameter int NUM_PRIORITIES = SPQ_NUM_PRIORITIES,
    parameter int QUEUE_DEPTH    = SPQ_QUEUE_DEPTH,
    parameter int MAX_SEND       = SPQ_MAX_SEND
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [SPQ_PRIO_W-1:0]   s_priority_req,
    input  logic [SPQ_HANDLE_W-1:0] s_packet_handle,
    input  logic [SPQ_LIMIT_W-1:0]  s_send_limit,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SPQ_HANDLE_W-1:0] m_packet_handle_res,
    output logic [SPQ_PRIO_W-1:0]   m_priority_res,
    output logic                    m_none_sent,
    output logic                    m_last
);

    localparam int CLS_W  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH + 2);
    localparam int ADDR_W = CLS_W + SLOT_W;
    localparam int LIM_CAP_I = (MAX_SEND < SPQ_RESULT_CAP) ? MAX_SEND : SPQ_RESULT_CAP;

    localparam logic [FILL_W-1:0]      QD_FILL = FILL_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0]       QD_IDX  = IDX_W'(QUEUE_DEPTH);
    localparam logic [SPQ_LIMIT_W-1:0] LIM_CAP = SPQ_LIMIT_W'(LIM_CAP_I);

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] head,
                                                    input logic [IDX_W-1:0]  idx);
        logic [IDX_W:0] sum;
        sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(idx);
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    spq_state_t state_reg, state_next;

    logic [SLOT_W-1:0] head_reg [NUM_PRIORITIES];
    logic [SLOT_W-1:0] head_next [NUM_PRIORITIES];
    logic [FILL_W-1:0] fill_reg [NUM_PRIORITIES];
    logic [FILL_W-1:0] fill_next [NUM_PRIORITIES];

    logic [CLS_W-1:0]        cls_reg, cls_next;
    logic [SPQ_HANDLE_W-1:0] handle_reg, handle_next;
    logic [IDX_W-1:0]        rd_reg, rd_next;
    logic [IDX_W-1:0]        wr_reg, wr_next;
    logic                    pend_reg, pend_next;
    logic [SPQ_LIMIT_W-1:0]  lim_reg, lim_next;
    logic [SPQ_LIMIT_W-1:0]  cnt_reg, cnt_next;
    logic [CLS_W-1:0]        out_cls_reg, out_cls_next;
    logic                    out_last_reg, out_last_next;

    logic                    m_valid_reg, m_valid_next;
    logic [SPQ_HANDLE_W-1:0] m_handle_reg, m_handle_next;
    logic [SPQ_PRIO_W-1:0]   m_prio_reg, m_prio_next;
    logic                    m_none_reg, m_none_next;
    logic                    m_last_reg, m_last_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [SPQ_HANDLE_W-1:0] ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [SPQ_HANDLE_W-1:0] ram_rdata;

    logic [NUM_PRIORITIES-1:0] nonempty;
    logic [NUM_PRIORITIES-1:0] mask_after;
    logic [CLS_W-1:0]          top_cls;
    logic [CLS_W-1:0]          in_cls;
    logic                      in_cls_ok;
    logic [CLS_W-1:0]          sel_cls;
    logic [SLOT_W-1:0]         sel_head;
    logic [FILL_W-1:0]         sel_fill;
    logic [SPQ_LIMIT_W-1:0]    eff_limit;
    logic                      last_calc;

    spq_ram #(
        .WIDTH (SPQ_HANDLE_W),
        .DEPTH (1 << ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        top_cls = '0;
        for (int c = 0; c < NUM_PRIORITIES; c++) begin
            nonempty[c] = (fill_reg[c] != '0);
            if (fill_reg[c] != '0) begin
                top_cls = CLS_W'(c);
            end
        end
    end

    assign in_cls    = CLS_W'(s_priority_req);
    assign in_cls_ok = (32'(s_priority_req) < NUM_PRIORITIES);

    always_comb begin
        unique case (state_reg)
            ST_IDLE:    sel_cls = in_cls;
            ST_COMPACT: sel_cls = cls_reg;
            default:    sel_cls = top_cls;
        endcase
    end

    assign sel_head = head_reg[sel_cls];
    assign sel_fill = fill_reg[sel_cls];

    always_comb begin
        mask_after = nonempty;
        if (sel_fill == FILL_W'(1)) begin
            mask_after[sel_cls] = 1'b0;
        end
    end

    assign last_calc = ((cnt_reg + SPQ_LIMIT_W'(1)) == lim_reg) || (mask_after == '0);

    always_comb begin
        if (s_send_limit == '0) begin
            eff_limit = SPQ_LIMIT_W'(1);
        end else if (s_send_limit > LIM_CAP) begin
            eff_limit = LIM_CAP;
        end else begin
            eff_limit = s_send_limit;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        cls_next      = cls_reg;
        handle_next   = handle_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        pend_next     = pend_reg;
        lim_next      = lim_reg;
        cnt_next      = cnt_reg;
        out_cls_next  = out_cls_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_valid_reg;
        m_handle_next = m_handle_reg;
        m_prio_next   = m_prio_reg;
        m_none_next   = m_none_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = handle_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == SPQ_CMD_RECEIVE) begin
                        if (in_cls_ok) begin
                            if (sel_fill == QD_FILL) begin
                                cls_next    = in_cls;
                                handle_next = s_packet_handle;
                                rd_next     = IDX_W'(2);
                                wr_next     = IDX_W'(1);
                                pend_next   = 1'b0;
                                state_next  = ST_COMPACT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = {in_cls, wrap_slot(sel_head, IDX_W'(sel_fill))};
                                ram_wdata = s_packet_handle;
                                fill_next[in_cls] = sel_fill + FILL_W'(1);
                            end
                        end
                    end else begin
                        lim_next   = eff_limit;
                        cnt_next   = '0;
                        state_next = ST_SEND_RD;
                    end
                end
            end
            ST_COMPACT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = {cls_reg, wrap_slot(sel_head, wr_reg)};
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + IDX_W'(1);
                end
                if (rd_reg < QD_IDX) begin
                    ram_re    = 1'b1;
                    ram_raddr = {cls_reg, wrap_slot(sel_head, rd_reg)};
                    rd_next   = rd_reg + IDX_W'(2);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && rd_reg >= QD_IDX) begin
                    // survivors packed; append the new handle behind them
                    ram_we    = 1'b1;
                    ram_waddr = {cls_reg, wrap_slot(sel_head, wr_reg)};
                    ram_wdata = handle_reg;
                    fill_next[cls_reg] = FILL_W'(wr_reg + IDX_W'(1));
                    state_next = ST_IDLE;
                end
            end
            ST_SEND_RD: begin
                if (!m_valid_reg) begin
                    if (nonempty != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = {top_cls, sel_head};
                        head_next[top_cls] = (32'(sel_head) == QUEUE_DEPTH - 1) ? '0
                                             : sel_head + SLOT_W'(1);
                        fill_next[top_cls] = sel_fill - FILL_W'(1);
                        cnt_next      = cnt_reg + SPQ_LIMIT_W'(1);
                        out_cls_next  = top_cls;
                        out_last_next = last_calc;
                        state_next    = ST_SEND_WAIT;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_handle_next = '0;
                        m_prio_next   = '0;
                        m_none_next   = 1'b1;
                        m_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_SEND_WAIT: begin
                m_valid_next  = 1'b1;
                m_handle_next = ram_rdata;
                m_prio_next   = SPQ_PRIO_W'(out_cls_reg);
                m_none_next   = 1'b0;
                m_last_next   = out_last_reg;
                state_next    = out_last_reg ? ST_IDLE : ST_SEND_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            for (int c = 0; c < NUM_PRIORITIES; c++) begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_next_hold: begin
            cls_reg      <= cls_next;
            handle_reg   <= handle_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            lim_reg      <= lim_next;
            cnt_reg      <= cnt_next;
            out_cls_reg  <= out_cls_next;
            out_last_reg <= out_last_next;
            m_handle_reg <= m_handle_next;
            m_prio_reg   <= m_prio_next;
            m_none_reg   <= m_none_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_packet_handle_res = m_handle_reg;
    assign m_priority_res      = m_prio_reg;
    assign m_none_sent         = m_none_reg;
    assign m_last              = m_last_reg;

endmodule

/* rtl/spq_ram.sv */
// spq_ram: generic simple dual-port RAM, one write and one registered read port.
// Uses spq_pkg for its parameter defaults.
module spq_ram
    import spq_pkg::*;
#(
    parameter int WIDTH = SPQ_HANDLE_W,
    parameter int DEPTH = SPQ_NUM_PRIORITIES * SPQ_QUEUE_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/spq_checker.sv */
// spq_checker: port-level assertions for strict_priority_packet_queues, bound to the top.
// Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic [SPQ_PRIO_W-1:0]   s_priority_req,
    input logic [SPQ_HANDLE_W-1:0] s_packet_handle,
    input logic [SPQ_LIMIT_W-1:0]  s_send_limit,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [SPQ_HANDLE_W-1:0] m_packet_handle_res,
    input logic [SPQ_PRIO_W-1:0]   m_priority_res,
    input logic                    m_none_sent,
    input logic                    m_last
);

    // stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_handle_res)
            && $stable(m_priority_res) && $stable(m_none_sent) && $stable(m_last))
        else $error("result changed while stalled");

    a_none_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_none_sent |-> m_last && (m_packet_handle_res == '0)
            && (m_priority_res == '0))
        else $error("empty-send result malformed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // a receive never produces a result by itself
    a_recv_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == SPQ_CMD_RECEIVE) && !m_valid |=> !m_valid)
        else $error("result after receive");

endmodule

bind strict_priority_packet_queues spq_checker u_spq_checker (.*);

/* tb/spq_dispatch_checker.sv */
// spq_dispatch_checker: watches both channels of strict_priority_packet_queues, predicts
// every dispatched handle from its own copy of the class FIFOs and compares field by field.
// Depends on spq_pkg; instantiated beside the block by strict_priority_packet_queues_tb.
module spq_dispatch_checker
    import spq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_command,
    input  logic [SPQ_PRIO_W-1:0]   s_priority_req,
    input  logic [SPQ_HANDLE_W-1:0] s_packet_handle,
    input  logic [SPQ_LIMIT_W-1:0]  s_send_limit,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [SPQ_HANDLE_W-1:0] m_packet_handle_res,
    input  logic [SPQ_PRIO_W-1:0]   m_priority_res,
    input  logic                    m_none_sent,
    input  logic                    m_last,
    output int                      mismatch_count,
    output int                      pending_dispatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SPQ_HANDLE_W-1:0] handle;
        logic [SPQ_PRIO_W-1:0]   prio;
        logic                    none_sent;
        logic                    last;
    } dispatch_t;

    logic [SPQ_HANDLE_W-1:0] class_store [SPQ_NUM_PRIORITIES][SPQ_QUEUE_DEPTH];
    int unsigned             class_fill  [SPQ_NUM_PRIORITIES];
    dispatch_t               expected_dispatches [$];

    initial begin
        mismatch_count     = 0;
        pending_dispatches = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_dispatch(input logic cmd, input logic [SPQ_PRIO_W-1:0] prio,
                                    input logic [SPQ_HANDLE_W-1:0] handle,
                                    input logic [SPQ_LIMIT_W-1:0] limit);
        int unsigned lim;
        int unsigned sent;
        int unsigned kept;
        int          found_class;
        dispatch_t   d;
        if (cmd == SPQ_CMD_RECEIVE) begin
            if (prio < SPQ_NUM_PRIORITIES) begin
                // full class: keep first, third, fifth ... entries
                if (class_fill[prio] >= SPQ_QUEUE_DEPTH) begin
                    kept = 0;
                    for (int i = 0; i < class_fill[prio]; i += 2) begin
                        class_store[prio][kept] = class_store[prio][i];
                        kept++;
                    end
                    class_fill[prio] = kept;
                end
                class_store[prio][class_fill[prio]] = handle;
                class_fill[prio]++;
            end
        end else begin
            lim = 32'(limit);
            if (lim == 0) lim = 1;
            if (lim > SPQ_MAX_SEND) lim = SPQ_MAX_SEND;
            if (lim > SPQ_RESULT_CAP) lim = SPQ_RESULT_CAP;
            sent = 0;
            while (sent < lim) begin
                found_class = -1;
                for (int c = SPQ_NUM_PRIORITIES - 1; c >= 0; c--) begin
                    if (found_class < 0 && class_fill[c] > 0) found_class = c;
                end
                if (found_class < 0) break;
                d.handle    = class_store[found_class][0];
                d.prio      = found_class[SPQ_PRIO_W-1:0];
                d.none_sent = 1'b0;
                d.last      = 1'b0;
                for (int i = 1; i < class_fill[found_class]; i++) begin
                    class_store[found_class][i-1] = class_store[found_class][i];
                end
                class_fill[found_class]--;
                expected_dispatches.push_back(d);
                sent++;
            end
            if (sent == 0) begin
                d = '{handle: '0, prio: '0, none_sent: 1'b1, last: 1'b1};
                expected_dispatches.push_back(d);
            end else begin
                d = expected_dispatches[expected_dispatches.size()-1];
                d.last = 1'b1;
                expected_dispatches[expected_dispatches.size()-1] = d;
            end
        end
    endtask

    task automatic check_dispatch();
        dispatch_t want;
        if (expected_dispatches.size() == 0) begin
            report_mismatch("unexpected transfer, handle", 32'(m_packet_handle_res), 32'd0);
        end else begin
            want = expected_dispatches.pop_front();
            if (m_packet_handle_res !== want.handle)
                report_mismatch("packet_handle_res", 32'(m_packet_handle_res),
                                32'(want.handle));
            if (m_priority_res !== want.prio)
                report_mismatch("priority_res", 32'(m_priority_res), 32'(want.prio));
            if (m_none_sent !== want.none_sent)
                report_mismatch("none_sent", 32'(m_none_sent), 32'(want.none_sent));
            if (m_last !== want.last)
                report_mismatch("last", 32'(m_last), 32'(want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < SPQ_NUM_PRIORITIES; c++) class_fill[c] = 0;
            expected_dispatches.delete();
        end else begin
            if (m_valid && m_ready) check_dispatch();
            if (s_valid && s_ready)
                predict_dispatch(s_command, s_priority_req, s_packet_handle, s_send_limit);
        end
        pending_dispatches <= expected_dispatches.size();
    end

endmodule

/* tb/strict_priority_packet_queues_tb.sv */
// strict_priority_packet_queues_tb: drives receive and send commands with bursty timing
// and a stalling receiver; checking is done by spq_dispatch_checker.
// Depends on spq_pkg, strict_priority_packet_queues and spq_dispatch_checker.
module strict_priority_packet_queues_tb
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int SEGMENT_ITEMS = 40;
    localparam int DRAIN_EVERY   = 100;
    localparam int TAIL_CYCLES   = 40;

    localparam logic [1:0] RX_ALWAYS = 2'd0;
    localparam logic [1:0] RX_COIN   = 2'd1;
    localparam logic [1:0] RX_BURSTY = 2'd2;
    localparam logic [1:0] RX_SPARSE = 2'd3;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic                    aclk;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic                    s_command       = SPQ_CMD_RECEIVE;
    logic [SPQ_PRIO_W-1:0]   s_priority_req  = '0;
    logic [SPQ_HANDLE_W-1:0] s_packet_handle = '0;
    logic [SPQ_LIMIT_W-1:0]  s_send_limit    = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [SPQ_HANDLE_W-1:0] m_packet_handle_res;
    logic [SPQ_PRIO_W-1:0]   m_priority_res;
    logic                    m_none_sent;
    logic                    m_last;
    int                      mismatch_count;
    int                      pending_dispatches;
    int                      burst_left      = 0;
    logic [8:0]              ready_phase     = '0;

    strict_priority_packet_queues dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_command, .s_priority_req, .s_packet_handle, .s_send_limit,
        .m_valid, .m_ready, .m_packet_handle_res, .m_priority_res, .m_none_sent, .m_last
    );

    spq_dispatch_checker checker_i (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_command, .s_priority_req, .s_packet_handle, .s_send_limit,
        .m_valid, .m_ready, .m_packet_handle_res, .m_priority_res, .m_none_sent, .m_last,
        .mismatch_count, .pending_dispatches
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver stall pattern, mode taken from ready_phase[8:7]
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 9'd1;
        case (ready_phase[8:7])
            RX_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            RX_BURSTY: begin
                m_ready <= (ready_phase[3:0] < 4'd6);
            end
            RX_SPARSE: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic push_command(input logic cmd, input logic [SPQ_PRIO_W-1:0] prio,
                                input logic [SPQ_HANDLE_W-1:0] handle,
                                input logic [SPQ_LIMIT_W-1:0] limit);
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_priority_req  <= prio;
        s_packet_handle <= handle;
        s_send_limit    <= limit;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 20);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_dispatches != 0) @(posedge aclk);
    endtask

    initial begin
        int mix;
        int recv_pct;
        logic [SPQ_PRIO_W-1:0] focus_prio;
        logic cmd;
        logic [SPQ_PRIO_W-1:0] prio;
        logic [SPQ_LIMIT_W-1:0] limit;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queues, zero limit, handle extremes, saturated limit, compaction
        push_command(SPQ_CMD_SEND, 3'd0, 16'h0000, 5'd1);
        push_command(SPQ_CMD_SEND, 3'd7, 16'hFFFF, 5'd0);
        push_command(SPQ_CMD_RECEIVE, 3'd0, 16'h0000, 5'd31);
        push_command(SPQ_CMD_RECEIVE, 3'd7, 16'hFFFF, 5'd0);
        push_command(SPQ_CMD_RECEIVE, 3'd3, 16'hA5A5, 5'd16);
        push_command(SPQ_CMD_RECEIVE, 3'd7, 16'h5A5A, 5'd1);
        push_command(SPQ_CMD_SEND, 3'd0, 16'h0000, 5'd0);
        push_command(SPQ_CMD_SEND, 3'd0, 16'h0000, 5'd31);
        for (int i = 0; i < SPQ_QUEUE_DEPTH + 1; i++) begin
            push_command(SPQ_CMD_RECEIVE, 3'd5, 16'(16'h1000 + i), 5'd1);
        end
        push_command(SPQ_CMD_RECEIVE, 3'd4, 16'h0F0F, 5'd1);
        push_command(SPQ_CMD_SEND, 3'd0, 16'h0000, 5'd17);
        push_command(SPQ_CMD_SEND, 3'd2, 16'h1234, 5'd16);
        wait_drained();

        mix        = MIX_EVEN;
        recv_pct   = 60;
        focus_prio = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                mix        = $urandom_range(MIX_FILL, MIX_EVEN);
                focus_prio = SPQ_PRIO_W'($urandom_range(0, SPQ_NUM_PRIORITIES - 1));
                recv_pct   = (mix == MIX_FILL) ? 90 : (mix == MIX_DRAIN) ? 25 : 60;
            end
            if (n != 0 && n % DRAIN_EVERY == 0) wait_drained();
            cmd   = ($urandom_range(0, 99) < recv_pct) ? SPQ_CMD_RECEIVE : SPQ_CMD_SEND;
            prio  = ($urandom_range(0, 2) != 0) ? focus_prio
                    : SPQ_PRIO_W'($urandom_range(0, SPQ_NUM_PRIORITIES - 1));
            limit = ($urandom_range(0, 9) == 0) ? SPQ_LIMIT_W'($urandom_range(0, 31))
                                                : SPQ_LIMIT_W'($urandom_range(1, 16));
            push_command(cmd, prio, 16'($urandom), limit);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_dispatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* strict_priority_packet_queues.f */
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/strict_priority_packet_queues.sv
rtl/spq_checker.sv
tb/spq_dispatch_checker.sv
tb/strict_priority_packet_queues_tb.sv
